/* rtl/core/gcm_pkg.sv */
package gcm_pkg;

    // Field widths
    localparam int AMOUNT_W = 24;
    localparam int REM_W    = AMOUNT_W - 1;
    localparam int DEN_W    = 16;
    localparam int CNT_W    = 16;
    localparam int TOT_W    = 16;
    localparam int SML_W    = 4;
    localparam int STAT_W   = 2;

    // Denomination tables
    localparam int TABLE_LEN = 16;
    localparam int IDX_W     = $clog2(TABLE_LEN);

    localparam int BILL_TABLE_SIZE = 15;
    localparam int COIN_TABLE_SIZE = 8;

    localparam logic [DEN_W-1:0] SMALL_LIMIT = 16'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NEG  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd2;

    // Table select codes
    localparam logic SET_COIN = 1'b0;
    localparam logic SET_BILL = 1'b1;

    // Reciprocals for the first (large quotient) step: q ~= (x * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 24;
    localparam longint COIN_FIRST_DEN = 200;
    localparam longint BILL_FIRST_DEN = 50000;
    localparam logic [RECIP_W-1:0] RECIP_COIN =
        RECIP_W'((64'd1 << RECIP_SHIFT) / COIN_FIRST_DEN);
    localparam logic [RECIP_W-1:0] RECIP_BILL =
        RECIP_W'((64'd1 << RECIP_SHIFT) / BILL_FIRST_DEN);

    function automatic logic [DEN_W-1:0] den_lookup(input logic set,
                                                    input logic [IDX_W-1:0] idx);
        logic [DEN_W-1:0] d;
        d = '0;
        if (set == SET_BILL) begin
            case (idx)
                4'd0:    d = 16'd50000;
                4'd1:    d = 16'd20000;
                4'd2:    d = 16'd10000;
                4'd3:    d = 16'd5000;
                4'd4:    d = 16'd2000;
                4'd5:    d = 16'd1000;
                4'd6:    d = 16'd500;
                4'd7:    d = 16'd200;
                4'd8:    d = 16'd100;
                4'd9:    d = 16'd50;
                4'd10:   d = 16'd20;
                4'd11:   d = 16'd10;
                4'd12:   d = 16'd5;
                4'd13:   d = 16'd2;
                4'd14:   d = 16'd1;
                default: d = 16'd0;
            endcase
        end else begin
            case (idx)
                4'd0:    d = 16'd200;
                4'd1:    d = 16'd100;
                4'd2:    d = 16'd50;
                4'd3:    d = 16'd20;
                4'd4:    d = 16'd10;
                4'd5:    d = 16'd5;
                4'd6:    d = 16'd2;
                4'd7:    d = 16'd1;
                default: d = 16'd0;
            endcase
        end
        return d;
    endfunction

    // Smallest nonzero denomination among the first size entries
    function automatic logic [DEN_W-1:0] smallest_den(input logic set, input int size);
        logic [DEN_W-1:0] r;
        logic [DEN_W-1:0] d;
        r = '0;
        for (int i = 0; i < TABLE_LEN; i++) begin
            d = den_lookup(set, IDX_W'(i));
            if (i < size && d != '0) begin
                r = d;
            end
        end
        return r;
    endfunction

    typedef struct packed {
        logic load;          // take a new amount
        logic mul;           // reciprocal multiply for the first entry
        logic prod;          // back-multiply, first remainder
        logic step;          // walk one table entry
        logic emit_special;  // single invalid / empty / no-piece result
    } cmd_t;

    typedef struct packed {
        logic special;   // accepted amount gives one special result
        logic emit;      // current entry has a nonzero count
        logic last;      // current entry is the final piece
        logic at_end;    // current entry is the last one walked
        logic out_free;  // output register can take a beat
    } stat_t;

endpackage

/* rtl/core/gcm_ctrl.sv */
module gcm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gcm_pkg::stat_t    stat,
    output gcm_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL     = 3'd1;
    localparam logic [2:0] S_PROD    = 3'd2;
    localparam logic [2:0] S_STEP    = 3'd3;
    localparam logic [2:0] S_SPECIAL = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.special ? S_SPECIAL : S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_PROD;
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = S_STEP;
            end
            S_STEP: begin
                // hold only when there is a beat to send and no room for it
                if (!stat.emit || stat.out_free) begin
                    cmd.step = 1'b1;
                    if ((stat.emit && stat.last) || stat.at_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SPECIAL: begin
                if (stat.out_free) begin
                    cmd.emit_special = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/gcm_datapath.sv */
module gcm_datapath #(
    parameter int BILL_TABLE_SIZE = gcm_pkg::BILL_TABLE_SIZE,
    parameter int COIN_TABLE_SIZE = gcm_pkg::COIN_TABLE_SIZE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic                          cfg_wdata,
    input  logic [gcm_pkg::AMOUNT_W-1:0]  s_amount_cents,
    input  gcm_pkg::cmd_t                 cmd,
    output gcm_pkg::stat_t                stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcm_pkg::DEN_W-1:0]     m_denomination_cents,
    output logic [gcm_pkg::CNT_W-1:0]     m_piece_count,
    output logic [gcm_pkg::TOT_W-1:0]     m_total_pieces,
    output logic [gcm_pkg::SML_W-1:0]     m_small_pieces,
    output logic [gcm_pkg::STAT_W-1:0]    m_status,
    output logic                          m_last
);

    localparam int REM_W   = gcm_pkg::REM_W;
    localparam int DEN_W   = gcm_pkg::DEN_W;
    localparam int CNT_W   = gcm_pkg::CNT_W;
    localparam int TOT_W   = gcm_pkg::TOT_W;
    localparam int SML_W   = gcm_pkg::SML_W;
    localparam int IDX_W   = gcm_pkg::IDX_W;
    localparam int RECIP_W = gcm_pkg::RECIP_W;
    localparam int MUL_W   = REM_W + RECIP_W;

    localparam int BILL_SIZE = (BILL_TABLE_SIZE > gcm_pkg::TABLE_LEN) ?
                               gcm_pkg::TABLE_LEN : BILL_TABLE_SIZE;
    localparam int COIN_SIZE = (COIN_TABLE_SIZE > gcm_pkg::TABLE_LEN) ?
                               gcm_pkg::TABLE_LEN : COIN_TABLE_SIZE;
    localparam logic [IDX_W-1:0] BILL_LAST_IDX = IDX_W'(BILL_SIZE - 1);
    localparam logic [IDX_W-1:0] COIN_LAST_IDX = IDX_W'(COIN_SIZE - 1);
    localparam logic [DEN_W-1:0] BILL_MIN_DEN  =
        gcm_pkg::smallest_den(gcm_pkg::SET_BILL, BILL_SIZE);
    localparam logic [DEN_W-1:0] COIN_MIN_DEN  =
        gcm_pkg::smallest_den(gcm_pkg::SET_COIN, COIN_SIZE);
    localparam logic [SML_W-1:0] SML_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // configuration
    logic set_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_reg <= gcm_pkg::SET_COIN;
        end else if (cfg_wen) begin
            set_reg <= cfg_wdata;
        end
    end

    // working registers
    logic [REM_W-1:0]           rem_reg;
    logic [CNT_W-1:0]           qbase_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [TOT_W-1:0]           tot_reg;
    logic [SML_W-1:0]           sml_reg;
    logic [gcm_pkg::STAT_W-1:0] spec_status_reg;

    logic [DEN_W-1:0]   min_den;
    logic [IDX_W-1:0]   last_idx;
    logic [RECIP_W-1:0] recip;
    logic [DEN_W-1:0]   first_den;

    assign min_den   = (set_reg == gcm_pkg::SET_BILL) ? BILL_MIN_DEN : COIN_MIN_DEN;
    assign last_idx  = (set_reg == gcm_pkg::SET_BILL) ? BILL_LAST_IDX : COIN_LAST_IDX;
    assign recip     = (set_reg == gcm_pkg::SET_BILL) ? gcm_pkg::RECIP_BILL :
                                                        gcm_pkg::RECIP_COIN;
    assign first_den = gcm_pkg::den_lookup(set_reg, '0);

    // input classification
    logic in_neg;
    logic in_zero;
    logic in_small;

    assign in_neg   = s_amount_cents[gcm_pkg::AMOUNT_W-1];
    assign in_zero  = (s_amount_cents == '0);
    assign in_small = (s_amount_cents[REM_W-1:0] < REM_W'(min_den));

    // first entry: reciprocal estimate, low by at most one
    logic [MUL_W-1:0] mul_full;
    logic [2*CNT_W-1:0] back_prod;

    assign mul_full  = MUL_W'(rem_reg) * MUL_W'(recip);
    assign back_prod = (2*CNT_W)'(qbase_reg) * (2*CNT_W)'(first_den);

    // table step: remainder is always below three times the entry, so at most 2 more
    logic [DEN_W-1:0]  den;
    logic              den_nz;
    logic [DEN_W:0]    den2;
    logic              ge1;
    logic              ge2;
    logic [1:0]        qstep;
    logic [REM_W-1:0]  rem_new;
    logic [CNT_W-1:0]  q;
    logic [TOT_W:0]    tot_sum;
    logic [TOT_W-1:0]  tot_next;
    logic [CNT_W:0]    sml_sum;
    logic [SML_W-1:0]  sml_next;

    assign den     = gcm_pkg::den_lookup(set_reg, idx_reg);
    assign den_nz  = (den != '0);
    assign den2    = {den, 1'b0};
    assign ge2     = den_nz && (rem_reg >= REM_W'(den2));
    assign ge1     = den_nz && (rem_reg >= REM_W'(den));
    assign qstep   = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);
    assign rem_new = ge2 ? (rem_reg - REM_W'(den2)) :
                     (ge1 ? (rem_reg - REM_W'(den)) : rem_reg);
    assign q       = qbase_reg + CNT_W'(qstep);

    assign tot_sum  = (TOT_W+1)'(tot_reg) + (TOT_W+1)'(q);
    assign tot_next = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];

    always_comb begin
        sml_next = sml_reg;
        if (den <= gcm_pkg::SMALL_LIMIT) begin
            sml_sum  = (CNT_W+1)'(sml_reg) + (CNT_W+1)'(q);
            sml_next = (sml_sum > (CNT_W+1)'(SML_MAX)) ? SML_MAX : sml_sum[SML_W-1:0];
        end else begin
            sml_sum  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg   <= s_amount_cents[REM_W-1:0];
            qbase_reg <= '0;
            idx_reg   <= '0;
            tot_reg   <= '0;
            sml_reg   <= '0;
            if (in_neg) begin
                spec_status_reg <= gcm_pkg::STATUS_NEG;
            end else if (in_zero) begin
                spec_status_reg <= gcm_pkg::STATUS_ZERO;
            end else begin
                spec_status_reg <= gcm_pkg::STATUS_OK;
            end
        end else if (cmd.mul) begin
            qbase_reg <= mul_full[MUL_W-1:gcm_pkg::RECIP_SHIFT];
        end else if (cmd.prod) begin
            rem_reg <= rem_reg - back_prod[REM_W-1:0];
        end else if (cmd.step) begin
            rem_reg   <= rem_new;
            qbase_reg <= '0;
            idx_reg   <= idx_reg + IDX_W'(1);
            tot_reg   <= tot_next;
            sml_reg   <= sml_next;
        end
    end

    // status
    logic out_free;

    assign out_free     = !m_valid || m_ready;
    assign stat.special = in_neg || in_zero || in_small;
    assign stat.emit    = (q != '0);
    assign stat.last    = (rem_new < REM_W'(min_den)) || (idx_reg == last_idx);
    assign stat.at_end  = (idx_reg == last_idx);
    assign stat.out_free = out_free;

    // output register
    logic load_step;

    assign load_step = cmd.step && stat.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (load_step || cmd.emit_special) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_special) begin
            m_denomination_cents <= '0;
            m_piece_count        <= '0;
            m_total_pieces       <= '0;
            m_small_pieces       <= '0;
            m_status             <= spec_status_reg;
            m_last               <= 1'b1;
        end else if (load_step) begin
            m_denomination_cents <= den;
            m_piece_count        <= q;
            m_total_pieces       <= tot_next;
            m_small_pieces       <= sml_next;
            m_status             <= gcm_pkg::STATUS_OK;
            m_last               <= stat.last;
        end
    end

    // error results are always single, empty and final
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != gcm_pkg::STATUS_OK) |->
            (m_last && m_denomination_cents == '0 && m_piece_count == '0))
        else $error("error result not final or not empty");

    // controller never sends a beat into a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd.step && stat.emit) || cmd.emit_special) |-> out_free)
        else $error("output beat overwritten");

    // after a step the remainder is below the entry just walked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && den_nz) |=> (rem_reg < REM_W'($past(den))))
        else $error("remainder not reduced below denomination");

endmodule

/* rtl/core/greedy_change_maker_unit.sv */
// Greedy change maker. Each beat on s_ carries an amount in integer cents (24-bit two's
// complement) and is broken into euro pieces, largest first: one m_ beat per denomination
// whose count is nonzero, each with running piece totals, the final one flagged by m_last.
// A negative amount gives one beat with status 1, zero gives one beat with status 2, and an
// amount below the smallest denomination walked gives one empty beat with status 0. The
// table is picked by cfg_wdata on a cfg_wen cycle (0: eight coins, 1: fifteen bills and
// coins); change it only while the block is idle. One amount is worked at a time: after
// acceptance a reciprocal multiply and a back-multiply settle the first, large quotient,
// then one table entry is walked per cycle, except while a beat waits for room in the
// output register, until the last piece. A negative, zero or too-small amount skips the
// multiply and the walk. The next amount is taken while the last beat of the previous
// one still waits in the output register.
module greedy_change_maker_unit #(
    parameter int BILL_TABLE_SIZE = gcm_pkg::BILL_TABLE_SIZE,
    parameter int COIN_TABLE_SIZE = gcm_pkg::COIN_TABLE_SIZE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wen,
    input  logic                          cfg_wdata,
    // amount in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gcm_pkg::AMOUNT_W-1:0]  s_amount_cents,
    // pieces out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcm_pkg::DEN_W-1:0]     m_denomination_cents,
    output logic [gcm_pkg::CNT_W-1:0]     m_piece_count,
    output logic [gcm_pkg::TOT_W-1:0]     m_total_pieces,
    output logic [gcm_pkg::SML_W-1:0]     m_small_pieces,
    output logic [gcm_pkg::STAT_W-1:0]    m_status,
    output logic                          m_last
);

    gcm_pkg::cmd_t  cmd;
    gcm_pkg::stat_t stat;

    // sequencer: accept, first-entry multiply, back-multiply, table walk, or a single special result
    gcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // remainder, running totals, table lookup and the output register
    gcm_datapath #(
        .BILL_TABLE_SIZE (BILL_TABLE_SIZE),
        .COIN_TABLE_SIZE (COIN_TABLE_SIZE)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wen              (cfg_wen),
        .cfg_wdata            (cfg_wdata),
        .s_amount_cents       (s_amount_cents),
        .cmd                  (cmd),
        .stat                 (stat),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_denomination_cents (m_denomination_cents),
        .m_piece_count        (m_piece_count),
        .m_total_pieces       (m_total_pieces),
        .m_small_pieces       (m_small_pieces),
        .m_status             (m_status),
        .m_last               (m_last)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    // one result beat, packed the same way for expectation and capture
    typedef struct packed {
        logic [gcm_pkg::DEN_W-1:0]  den;
        logic [gcm_pkg::CNT_W-1:0]  cnt;
        logic [gcm_pkg::TOT_W-1:0]  tot;
        logic [gcm_pkg::SML_W-1:0]  sml;
        logic [gcm_pkg::STAT_W-1:0] status;
        logic                       last;
    } piece_t;

    // denominations walked largest first; zero entries are skipped
    localparam int unsigned COIN_DENOMS[gcm_pkg::TABLE_LEN] = '{
        200, 100, 50, 20, 10, 5, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam int unsigned BILL_DENOMS[gcm_pkg::TABLE_LEN] = '{
        50000, 20000, 10000, 5000, 2000, 1000, 500, 200,
        100, 50, 20, 10, 5, 2, 1, 0
    };

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           cfg_wen = 1'b0;
    logic                           cfg_wdata = gcm_pkg::SET_COIN;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [gcm_pkg::AMOUNT_W-1:0]   s_amount_cents = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [gcm_pkg::DEN_W-1:0]      m_denomination_cents;
    logic [gcm_pkg::CNT_W-1:0]      m_piece_count;
    logic [gcm_pkg::TOT_W-1:0]      m_total_pieces;
    logic [gcm_pkg::SML_W-1:0]      m_small_pieces;
    logic [gcm_pkg::STAT_W-1:0]     m_status;
    logic                           m_last;

    logic [gcm_pkg::AMOUNT_W-1:0]   amounts_pending[$];   // amounts not yet driven
    piece_t                         pieces_due[$];        // beats predicted, not yet seen
    logic                           denom_set = gcm_pkg::SET_COIN; // shadow of table select
    logic                           amt_taken = 1'b0;     // s_ beat accepted at last edge
    int                             src_idle_pct = 0;
    int                             snk_idle_pct = 0;
    int                             mismatches = 0;

    greedy_change_maker_unit u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wen              (cfg_wen),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_amount_cents       (s_amount_cents),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_denomination_cents (m_denomination_cents),
        .m_piece_count        (m_piece_count),
        .m_total_pieces       (m_total_pieces),
        .m_small_pieces       (m_small_pieces),
        .m_status             (m_status),
        .m_last               (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Greedy breakdown of one amount into the beats it should produce.
    // Negative and zero amounts give a single flagged beat; a positive amount
    // that yields no piece gives a single empty beat with status ok.
    function automatic void make_change(input logic [gcm_pkg::AMOUNT_W-1:0] amt,
                                        input logic set);
        piece_t      p;
        piece_t      run[$];
        int unsigned rem;
        int unsigned d;
        int unsigned c;
        int unsigned tot;
        int unsigned sml;
        int unsigned size;
        p = '0;
        if (amt[gcm_pkg::AMOUNT_W-1]) begin
            p.status = gcm_pkg::STATUS_NEG;
            p.last   = 1'b1;
            pieces_due = {pieces_due, p};
            return;
        end
        if (amt == '0) begin
            p.status = gcm_pkg::STATUS_ZERO;
            p.last   = 1'b1;
            pieces_due = {pieces_due, p};
            return;
        end
        size = (set == gcm_pkg::SET_BILL) ? gcm_pkg::BILL_TABLE_SIZE :
                                            gcm_pkg::COIN_TABLE_SIZE;
        if (size > gcm_pkg::TABLE_LEN) begin
            size = gcm_pkg::TABLE_LEN;
        end
        rem = amt;
        tot = 0;
        sml = 0;
        for (int i = 0; i < size && run.size() < 15; i++) begin
            d = (set == gcm_pkg::SET_BILL) ? BILL_DENOMS[i] : COIN_DENOMS[i];
            if (d == 0) begin
                continue;
            end
            c = rem / d;
            if (c == 0) begin
                continue;
            end
            rem -= c * d;
            tot += c;
            if (tot > 16'hFFFF) begin
                tot = 16'hFFFF;
            end
            if (d <= gcm_pkg::SMALL_LIMIT) begin
                sml += c;
                if (sml > 15) begin
                    sml = 15;
                end
            end
            p.den    = d[gcm_pkg::DEN_W-1:0];
            p.cnt    = c[gcm_pkg::CNT_W-1:0];
            p.tot    = tot[gcm_pkg::TOT_W-1:0];
            p.sml    = sml[gcm_pkg::SML_W-1:0];
            p.status = gcm_pkg::STATUS_OK;
            p.last   = 1'b0;
            run = {run, p};
        end
        if (run.size() == 0) begin
            p = '0;
            p.status = gcm_pkg::STATUS_OK;
            p.last   = 1'b1;
            pieces_due = {pieces_due, p};
            return;
        end
        run[run.size()-1].last = 1'b1;
        pieces_due = {pieces_due, run};
    endfunction

    // Rising edge: track the table select, predict on each accepted amount.
    always @(posedge aclk) begin
        if (!aresetn) begin
            denom_set <= gcm_pkg::SET_COIN;
            amt_taken <= 1'b0;
        end else begin
            if (cfg_wen) begin
                denom_set <= cfg_wdata;
            end
            amt_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                make_change(s_amount_cents, denom_set);
            end
        end
    end

    // Driver: falling edge. Valid is held with a stable payload until the beat
    // is taken; a new amount goes out only when the source is not idling.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || amt_taken) begin
            if (amounts_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_valid        <= 1'b1;
                s_amount_cents <= amounts_pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= snk_idle_pct);
    end

    // Monitor: every accepted m_ beat is checked against the oldest prediction.
    always @(posedge aclk) begin
        piece_t got;
        piece_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_denomination_cents, m_piece_count, m_total_pieces,
                    m_small_pieces, m_status, m_last};
            if (pieces_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t unexpected beat: den=%0d cnt=%0d tot=%0d sml=%0d",
                             $realtime, got.den, got.cnt, got.tot, got.sml,
                             "  st=%0d last=%0b", got.status, got.last);
                end
            end else begin
                want = pieces_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t beat mismatch: exp den=%0d cnt=%0d tot=%0d sml=%0d",
                                 $realtime, want.den, want.cnt, want.tot, want.sml,
                                 " st=%0d last=%0b", want.status, want.last);
                        $display("%0t                got den=%0d cnt=%0d tot=%0d sml=%0d",
                                 $realtime, got.den, got.cnt, got.tot, got.sml,
                                 " st=%0d last=%0b", got.status, got.last);
                    end
                end
            end
        end
    end

    // Random amount, weighted toward the interesting ranges.
    function automatic logic [gcm_pkg::AMOUNT_W-1:0] pick_amount();
        logic [gcm_pkg::AMOUNT_W-1:0] a;
        case ($urandom_range(9))
            0:       a = gcm_pkg::AMOUNT_W'($urandom);               // any bit pattern
            1:       a = {1'b1, 23'($urandom)};                      // negative
            2:       a = '0;                                         // nothing to change
            3, 4:    a = gcm_pkg::AMOUNT_W'($urandom_range(1, 400)); // a few coins
            5, 6:    a = gcm_pkg::AMOUNT_W'($urandom_range(1, 100000)); // bills and coins
            7:       a = gcm_pkg::AMOUNT_W'(24'h7FFFFF - $urandom_range(0, 1000)); // top
            8:       a = gcm_pkg::AMOUNT_W'($urandom_range(0, 40) * 200 +
                                            $urandom_range(1, 199));
            default: a = {1'b0, 23'($urandom)};                      // any positive
        endcase
        return a;
    endfunction

    // Block until every queued amount is in and every beat is out, then let the
    // pipeline settle (final beat plus a full bill walk) before touching config.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (amounts_pending.size() != 0 || s_valid || pieces_due.size() != 0);
        repeat (24) @(negedge aclk);
    endtask

    task automatic select_table(input logic set);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= set;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        @(posedge aclk);
        repeat (n) amounts_pending = {amounts_pending, pick_amount()};
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, coin table: sign edges, zero, extremes, small remainders,
        // one of every coin (388), just under / on the first coin
        src_idle_pct = 12;
        snk_idle_pct = 53;
        select_table(gcm_pkg::SET_COIN);
        @(posedge aclk);
        amounts_pending = {amounts_pending,
                           24'd0, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                           24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd9,
                           24'd199, 24'd200, 24'd388, 24'd377};

        // directed, bill table: every denomination once (88888), top, boundaries
        select_table(gcm_pkg::SET_BILL);
        @(posedge aclk);
        amounts_pending = {amounts_pending,
                           24'd88888, 24'h7FFFFF, 24'd50000, 24'd49999,
                           24'd1, 24'd0, 24'h800001, 24'd8};

        // random: source light / sink heavy, then swapped, then free-running
        select_table(gcm_pkg::SET_COIN);
        queue_random(25);
        select_table(gcm_pkg::SET_BILL);
        queue_random(25);

        wait_idle();
        src_idle_pct = 53;
        snk_idle_pct = 12;
        select_table(gcm_pkg::SET_COIN);
        queue_random(24);
        select_table(gcm_pkg::SET_BILL);
        queue_random(24);

        wait_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        select_table(gcm_pkg::SET_COIN);
        queue_random(24);
        select_table(gcm_pkg::SET_BILL);
        queue_random(24);

        wait_idle();
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
